>>> sv/mmc3c_pkg.sv
// Shared types and constants for the MMC3-style clone bank mapper.
// Depends on nothing; the core, controller, datapath, checker and testbench import it.
`timescale 1ns / 1ps

package mmc3c_pkg;

    // Field widths.
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PRG_TOTAL_W = 8;
    localparam int unsigned CHR_TOTAL_W = 9;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned NT_MODE_W   = 3;
    localparam int unsigned MIRROR_W    = 2;

    // Pages below this number are pattern RAM.
    localparam int unsigned RAM_PAGES = 8;

    // The remainder lanes retire two dividend bits per step.
    localparam int unsigned BITS_PER_STEP = 2;
    localparam int unsigned ITER_STEPS    = BYTE_W / BITS_PER_STEP;
    localparam int unsigned STEP_CNT_W    = $clog2(ITER_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_TOTAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN = 2'd2;

    // CPU write decoding.
    localparam logic [ADDR_W-1:0] ADDR_MASK        = 16'hE001;
    localparam logic [ADDR_W-1:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [ADDR_W-1:0] ADDR_MIRROR      = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_LATCH   = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_RELOAD  = 16'hC001;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_DISABLE = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE  = 16'hE001;

    // Bank selector low-nibble targets.
    localparam logic [3:0] SEL_BANK_FIRST = 4'h0;
    localparam logic [3:0] SEL_BANK_LAST  = 4'h7;
    localparam logic [3:0] SEL_EXTRA0     = 4'hA;
    localparam logic [3:0] SEL_EXTRA1     = 4'hB;

    localparam logic [NT_MODE_W-1:0] NT_FOUR_SCREEN = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_ITER,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic update;   // apply the accepted request to the mapper state
        logic load;     // load the remainder lanes from the mapper state
        logic step;     // advance every remainder lane by one step
        logic capture;  // write the result register
    } t_dp_cmd;

endpackage

>>> sv/mmc3c_in_if.sv
// Request channel: one CPU register write or one scanline tick.
// Stand-alone interface; no dependencies.
`timescale 1ns / 1ps

interface mmc3c_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic        rendering_on;

    modport source (output valid, output kind, output cpu_address, output write_data,
                    output rendering_on, input ready);
    modport sink (input valid, input kind, input cpu_address, input write_data,
                  input rendering_on, output ready);
endinterface

>>> sv/mmc3c_out_if.sv
// Result channel: the complete bank mapping after each request.
// Stand-alone interface; no dependencies.
`timescale 1ns / 1ps

interface mmc3c_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] prg_banks;
    logic [31:0] chr_banks_low;
    logic [31:0] chr_banks_high;
    logic [7:0]  chr_ram_slots;
    logic [2:0]  nametable_mode;
    logic        irq_request;
    logic        irq_acknowledge;

    modport source (output valid, output prg_banks, output chr_banks_low,
                    output chr_banks_high, output chr_ram_slots, output nametable_mode,
                    output irq_request, output irq_acknowledge, input ready);
    modport sink (input valid, input prg_banks, input chr_banks_low,
                  input chr_banks_high, input chr_ram_slots, input nametable_mode,
                  input irq_request, input irq_acknowledge, output ready);
endinterface

>>> sv/mmc3_clone_bank_mapper_irq_core.sv
// Top level of the MMC3-style clone bank mapper with scanline interrupt.
// Depends on mmc3c_pkg, mmc3c_in_if, mmc3c_out_if, mmc3c_ctrl and mmc3c_dp.
//
//  Channel   Direction  Handshake              Carries
//  i_item    in         valid / ready          kind, cpu_address, write_data, rendering_on
//  o_result  out        valid / ready          bank mapping, nametable mode, irq pulses
//  i_cfg_*   in         write enable only      prg/chr bank totals, four-screen flag
//
// A request passes through the core in order: the accepting cycle updates the
// mapper state, a load step fills the ten remainder lanes, the lanes then step
// two bits at a time (bank number modulo bank count), and a final step writes
// the result register, which then offers the result.
// A new request is taken only after the previous result is written; a result
// held by a stalled sink delays that write.
// Reset is synchronous and active low and sets the documented power-on mapping.
`timescale 1ns / 1ps

module mmc3_clone_bank_mapper_irq_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mmc3c_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mmc3c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mmc3c_in_if.sink                         i_item,
    mmc3c_out_if.source                      o_result
);
    import mmc3c_pkg::*;

    t_dp_cmd w_cmd;

    mmc3c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    mmc3c_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_item.kind),
        .i_cpu_address     (i_item.cpu_address),
        .i_write_data      (i_item.write_data),
        .i_rendering_on    (i_item.rendering_on),
        .o_prg_banks       (o_result.prg_banks),
        .o_chr_banks_low   (o_result.chr_banks_low),
        .o_chr_banks_high  (o_result.chr_banks_high),
        .o_chr_ram_slots   (o_result.chr_ram_slots),
        .o_nametable_mode  (o_result.nametable_mode),
        .o_irq_request     (o_result.irq_request),
        .o_irq_acknowledge (o_result.irq_acknowledge)
    );

endmodule

>>> sv/mmc3c_ctrl.sv
// Sequencing controller: accept, load, iterate remainder lanes, deliver result.
// Depends on mmc3c_pkg.
`timescale 1ns / 1ps

module mmc3c_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output mmc3c_pkg::t_dp_cmd o_cmd
);
    import mmc3c_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [STEP_CNT_W-1:0] r_step_cnt;
    logic [STEP_CNT_W-1:0] n_step_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  w_last_step;
    logic                  w_out_free;

    assign w_last_step = (r_step_cnt == STEP_CNT_W'(ITER_STEPS - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_ITER;
            end
            S_ITER: begin
                if (w_last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.update = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
            end
            S_ITER: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.capture = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_step_cnt = '0;
        if (r_state == S_ITER) begin
            n_step_cnt = r_step_cnt + STEP_CNT_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step_cnt  <= n_step_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/mmc3c_dp.sv
// Datapath: mapper registers, scanline counter, remainder lanes, result register.
// Depends on mmc3c_pkg; driven by commands from mmc3c_ctrl.
`timescale 1ns / 1ps

module mmc3c_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmc3c_pkg::t_dp_cmd                  i_cmd,
    input  logic                                i_cfg_we,
    input  logic [mmc3c_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmc3c_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_kind,
    input  logic [mmc3c_pkg::ADDR_W-1:0]        i_cpu_address,
    input  logic [mmc3c_pkg::BYTE_W-1:0]        i_write_data,
    input  logic                                i_rendering_on,
    output logic [31:0]                         o_prg_banks,
    output logic [31:0]                         o_chr_banks_low,
    output logic [31:0]                         o_chr_banks_high,
    output logic [7:0]                          o_chr_ram_slots,
    output logic [mmc3c_pkg::NT_MODE_W-1:0]     o_nametable_mode,
    output logic                                o_irq_request,
    output logic                                o_irq_acknowledge
);
    import mmc3c_pkg::*;

    // One restoring-remainder step per retired dividend bit; the remainder stays below
    // the divisor and never exceeds the 8-bit dividend, so it fits in a byte.
    function automatic logic [BYTE_W-1:0] f_rem_step(
        input logic [BYTE_W-1:0]        rem,
        input logic [BITS_PER_STEP-1:0] bits,
        input logic [CHR_TOTAL_W-1:0]   div
    );
        logic [CHR_TOTAL_W-1:0] t;
        t = CHR_TOTAL_W'(rem);
        for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
            t = {t[BYTE_W-1:0], bits[b]};
            if (t >= div) begin
                t = t - div;
            end
        end
        return t[BYTE_W-1:0];
    endfunction

    // Configuration.
    logic [PRG_TOTAL_W-1:0] r_prg_total;
    logic [CHR_TOTAL_W-1:0] r_chr_total;
    logic                   r_four_screen;

    // Mapper state.
    logic [BYTE_W-1:0]   r_bank_sel;
    logic [BYTE_W-1:0]   r_bank_reg [8];
    logic [BYTE_W-1:0]   r_extra [2];
    logic [MIRROR_W-1:0] r_mirror;
    logic [BYTE_W-1:0]   r_irq_reload;
    logic [BYTE_W-1:0]   r_irq_count;
    logic                r_irq_pending;
    logic                r_irq_enable;
    logic                r_req;
    logic                r_ack;

    // Remainder lanes: two program lanes and eight pattern lanes.
    logic [BYTE_W-1:0] r_prg_num [2];
    logic [BYTE_W-1:0] r_prg_rem [2];
    logic [BYTE_W-1:0] r_chr_src [8];
    logic [BYTE_W-1:0] r_chr_num [8];
    logic [BYTE_W-1:0] r_chr_rem [8];

    logic [ADDR_W-1:0]      w_addr_dec;
    logic [3:0]             w_sel;
    logic [BYTE_W-1:0]      w_count_next;
    logic [CHR_TOTAL_W-1:0] w_prg_div;
    logic [BYTE_W-1:0]      w_src [8];
    logic [BYTE_W-1:0]      w_last;
    logic [BYTE_W-1:0]      w_slast;
    logic [BYTE_W-1:0]      w_chr_page [8];
    logic [7:0]             w_chr_ram;

    assign w_addr_dec = i_cpu_address & ADDR_MASK;
    assign w_sel      = r_bank_sel[3:0];

    always_comb begin
        if ((r_irq_count == '0) || r_irq_pending) begin
            w_count_next = r_irq_reload;
        end else begin
            w_count_next = r_irq_count - BYTE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_total   <= PRG_TOTAL_W'(2);
            r_chr_total   <= '0;
            r_four_screen <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRG_TOTAL:   r_prg_total   <= i_cfg_data[PRG_TOTAL_W-1:0];
                CFG_CHR_TOTAL:   r_chr_total   <= i_cfg_data[CHR_TOTAL_W-1:0];
                CFG_FOUR_SCREEN: r_four_screen <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_sel    <= '0;
            for (int k = 0; k < 8; k++) begin
                r_bank_reg[k] <= (k == 7) ? BYTE_W'(1) : '0;
            end
            r_extra[0]    <= '0;
            r_extra[1]    <= '0;
            r_mirror      <= '0;
            r_irq_reload  <= '0;
            r_irq_count   <= '0;
            r_irq_pending <= 1'b0;
            r_irq_enable  <= 1'b0;
            r_req         <= 1'b0;
            r_ack         <= 1'b0;
        end else if (i_cmd.update) begin
            r_req <= 1'b0;
            r_ack <= 1'b0;
            if (!i_kind) begin
                unique case (w_addr_dec)
                    ADDR_BANK_SELECT: r_bank_sel <= i_write_data;
                    ADDR_BANK_DATA: begin
                        unique case (w_sel) inside
                            [SEL_BANK_FIRST:SEL_BANK_LAST]: r_bank_reg[w_sel[2:0]] <= i_write_data;
                            SEL_EXTRA0: r_extra[0] <= i_write_data;
                            SEL_EXTRA1: r_extra[1] <= i_write_data;
                            default: begin
                            end
                        endcase
                    end
                    ADDR_MIRROR:     r_mirror     <= i_write_data[MIRROR_W-1:0];
                    ADDR_IRQ_LATCH:  r_irq_reload <= i_write_data;
                    ADDR_IRQ_RELOAD: r_irq_pending <= 1'b1;
                    ADDR_IRQ_DISABLE: begin
                        r_irq_enable <= 1'b0;
                        r_ack        <= 1'b1;
                    end
                    ADDR_IRQ_ENABLE: r_irq_enable <= 1'b1;
                    default: begin
                    end
                endcase
            end else if (i_rendering_on) begin
                r_irq_count   <= w_count_next;
                r_req         <= (w_count_next == '0) && r_irq_enable;
                r_irq_pending <= 1'b0;
            end
        end
    end

    // A program count of zero behaves as 256, which leaves bank numbers as they are.
    assign w_prg_div = (r_prg_total == '0) ? CHR_TOTAL_W'(256) : CHR_TOTAL_W'(r_prg_total);

    always_comb begin
        if (!r_bank_sel[7]) begin
            w_src[0] = r_bank_reg[0]; w_src[1] = r_extra[0];
            w_src[2] = r_bank_reg[1]; w_src[3] = r_extra[1];
            w_src[4] = r_bank_reg[2]; w_src[5] = r_bank_reg[3];
            w_src[6] = r_bank_reg[4]; w_src[7] = r_bank_reg[5];
        end else begin
            w_src[0] = r_bank_reg[2]; w_src[1] = r_bank_reg[3];
            w_src[2] = r_bank_reg[4]; w_src[3] = r_bank_reg[5];
            w_src[4] = r_bank_reg[0]; w_src[5] = r_extra[0];
            w_src[6] = r_bank_reg[1]; w_src[7] = r_extra[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prg_num[0] <= r_bank_reg[6];
            r_prg_num[1] <= r_bank_reg[7];
            r_prg_rem[0] <= '0;
            r_prg_rem[1] <= '0;
            for (int s = 0; s < 8; s++) begin
                r_chr_src[s] <= w_src[s];
                r_chr_num[s] <= w_src[s];
                r_chr_rem[s] <= '0;
            end
        end else if (i_cmd.step) begin
            for (int p = 0; p < 2; p++) begin
                r_prg_rem[p] <= f_rem_step(r_prg_rem[p],
                                           r_prg_num[p][BYTE_W-1 -: BITS_PER_STEP], w_prg_div);
                r_prg_num[p] <= {r_prg_num[p][BYTE_W-BITS_PER_STEP-1:0],
                                 BITS_PER_STEP'(0)};
            end
            for (int s = 0; s < 8; s++) begin
                r_chr_rem[s] <= f_rem_step(r_chr_rem[s],
                                           r_chr_num[s][BYTE_W-1 -: BITS_PER_STEP], r_chr_total);
                r_chr_num[s] <= {r_chr_num[s][BYTE_W-BITS_PER_STEP-1:0],
                                 BITS_PER_STEP'(0)};
            end
        end
    end

    assign w_last  = r_prg_total - PRG_TOTAL_W'(1);
    assign w_slast = r_prg_total - PRG_TOTAL_W'(2);

    for (genvar g = 0; g < 8; g++) begin : g_slot
        localparam logic [BYTE_W-1:0] SLOT_RAM_PAGE = BYTE_W'(g % RAM_PAGES);
        always_comb begin
            if (r_chr_total == '0) begin
                w_chr_ram[g]  = 1'b1;
                w_chr_page[g] = SLOT_RAM_PAGE;
            end else if (r_chr_src[g] < BYTE_W'(RAM_PAGES)) begin
                w_chr_ram[g]  = 1'b1;
                w_chr_page[g] = r_chr_src[g];
            end else begin
                w_chr_ram[g]  = 1'b0;
                w_chr_page[g] = r_chr_rem[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if (!r_bank_sel[6]) begin
                o_prg_banks <= {w_last, w_slast, r_prg_rem[1], r_prg_rem[0]};
            end else begin
                o_prg_banks <= {w_last, r_prg_rem[0], r_prg_rem[1], w_slast};
            end
            o_chr_banks_low   <= {w_chr_page[3], w_chr_page[2], w_chr_page[1], w_chr_page[0]};
            o_chr_banks_high  <= {w_chr_page[7], w_chr_page[6], w_chr_page[5], w_chr_page[4]};
            o_chr_ram_slots   <= w_chr_ram;
            o_nametable_mode  <= r_four_screen ? NT_FOUR_SCREEN : NT_MODE_W'(r_mirror);
            o_irq_request     <= r_req;
            o_irq_acknowledge <= r_ack;
        end
    end

endmodule

>>> sv/mmc3c_chk.sv
// Port-level checks for the bank mapper core, attached to it by a bind.
// Depends on mmc3c_pkg and on the top level's ports.
`timescale 1ns / 1ps

module mmc3c_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [31:0]                      i_prg_banks,
    input logic [mmc3c_pkg::NT_MODE_W-1:0]  i_nametable_mode,
    input logic                             i_irq_request,
    input logic                             i_irq_acknowledge
);
    import mmc3c_pkg::*;

    // A result that is not taken stays offered with its program banks unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_prg_banks))
        else $error("stalled result changed or was dropped");

    // The core works on one request at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while another is in progress");

    // A tick raises requests and only a disable write acknowledges, never both.
    a_pulse_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_irq_request && i_irq_acknowledge))
        else $error("irq request and acknowledge in one result");

    a_nt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_nametable_mode <= NT_FOUR_SCREEN))
        else $error("nametable mode out of range");

endmodule

bind mmc3_clone_bank_mapper_irq_core mmc3c_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_item.valid),
    .i_in_ready        (i_item.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_prg_banks       (o_result.prg_banks),
    .i_nametable_mode  (o_result.nametable_mode),
    .i_irq_request     (o_result.irq_request),
    .i_irq_acknowledge (o_result.irq_acknowledge)
);

>>> tb/tb_mmc3_clone_bank_mapper_irq_core.sv
// Self-checking testbench for the MMC3-style clone bank mapper with scanline interrupt.
// Depends on mmc3c_pkg, mmc3c_in_if, mmc3c_out_if and the mmc3_clone_bank_mapper_irq_core RTL.
// A directed table runs first, then random register writes and ticks under several board setups.
`timescale 1ns / 1ps

module tb_mmc3_clone_bank_mapper_irq_core;
    import mmc3c_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 220;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        rend;
    } t_map_req;

    typedef struct packed {
        logic [31:0] prg;
        logic [31:0] chr_lo;
        logic [31:0] chr_hi;
        logic [7:0]  ram;
        logic [2:0]  nt;
        logic        irq_req;
        logic        irq_ack;
    } t_mapping;

    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_TYPED,
        ROW_SETUP
    } t_row_op;

    typedef struct {
        t_row_op    op;
        t_map_req   req;
        t_mapping   gold;
        logic [7:0] prg_total;
        logic [8:0] chr_total;
        logic       four;
    } t_plan_row;

    // Power-on mapping: R6=0, R7=1 modulo 2, fixed banks 0 and 1, every slot on its own RAM page.
    localparam t_mapping POWER_ON_MAP =
        '{32'h0100_0100, 32'h0302_0100, 32'h0706_0504, 8'hFF, 3'd0, 1'b0, 1'b0};
    localparam t_mapping POWER_ON_ACK_MAP =
        '{32'h0100_0100, 32'h0302_0100, 32'h0706_0504, 8'hFF, 3'd0, 1'b0, 1'b1};

    localparam logic [7:0] PH_PRG  [7] = '{8'd254, 8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd17};
    localparam logic [8:0] PH_CHR  [7] = '{9'd256, 9'd511, 9'd9, 9'd0, 9'd1, 9'd8, 9'd100};
    localparam logic       PH_FOUR [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    t_map_req in_req = '0;
    logic out_ready = 1'b0;
    logic steady = 1'b0;

    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    t_mapping mapping_q [$];
    t_plan_row plan [$];

    // Predictor copy of the board setup and mapper state.
    logic [7:0] cfg_prg_total = 8'd2;
    logic [8:0] cfg_chr_total = 9'd0;
    logic       cfg_four = 1'b0;
    logic [7:0] sel_reg = 8'd0;
    logic [7:0] bank_reg [8] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
    logic [7:0] extra_page [2] = '{8'd0, 8'd0};
    logic [1:0] mirror_reg = 2'd0;
    logic [7:0] latch_val = 8'd0;
    logic [7:0] scan_count = 8'd0;
    logic       reload_req = 1'b0;
    logic       irq_on = 1'b0;

    mmc3c_in_if  item_if ();
    mmc3c_out_if res_if ();

    assign item_if.valid        = in_valid;
    assign item_if.kind         = in_req.kind;
    assign item_if.cpu_address  = in_req.addr;
    assign item_if.write_data   = in_req.data;
    assign item_if.rendering_on = in_req.rend;
    assign res_if.ready         = out_ready;

    mmc3_clone_bank_mapper_irq_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one request to the predictor state and returns the mapping it reports.
    function automatic t_mapping apply_request(t_map_req r);
        t_mapping   m;
        logic [7:0] src [8];
        logic [3:0] nib;
        logic [7:0] last_bank;
        logic [7:0] slast_bank;
        logic [7:0] r6_bank;
        logic [7:0] r7_bank;
        logic [7:0] page;
        int         div;
        m = '0;
        if (!r.kind) begin
            case (r.addr & ADDR_MASK)
                ADDR_BANK_SELECT: sel_reg = r.data;
                ADDR_BANK_DATA: begin
                    nib = sel_reg[3:0];
                    if (nib == SEL_EXTRA0) extra_page[0] = r.data;
                    else if (nib == SEL_EXTRA1) extra_page[1] = r.data;
                    else if (nib <= SEL_BANK_LAST) bank_reg[nib[2:0]] = r.data;
                end
                ADDR_MIRROR:      mirror_reg = r.data[1:0];
                ADDR_IRQ_LATCH:   latch_val = r.data;
                ADDR_IRQ_RELOAD:  reload_req = 1'b1;
                ADDR_IRQ_DISABLE: begin
                    irq_on = 1'b0;
                    m.irq_ack = 1'b1;
                end
                ADDR_IRQ_ENABLE:  irq_on = 1'b1;
                default: ;
            endcase
        end else if (r.rend) begin
            if (scan_count == 8'd0 || reload_req) scan_count = latch_val;
            else scan_count = scan_count - 8'd1;
            if (scan_count == 8'd0 && irq_on) m.irq_req = 1'b1;
            reload_req = 1'b0;
        end

        // A program bank total of zero behaves as 256 banks.
        div = (cfg_prg_total == 8'd0) ? 256 : int'(cfg_prg_total);
        r6_bank = 8'(int'(bank_reg[6]) % div);
        r7_bank = 8'(int'(bank_reg[7]) % div);
        last_bank = cfg_prg_total - 8'd1;
        slast_bank = cfg_prg_total - 8'd2;
        if (!sel_reg[6]) m.prg = {last_bank, slast_bank, r7_bank, r6_bank};
        else m.prg = {last_bank, r6_bank, r7_bank, slast_bank};

        if (!sel_reg[7]) begin
            src = '{bank_reg[0], extra_page[0], bank_reg[1], extra_page[1],
                    bank_reg[2], bank_reg[3], bank_reg[4], bank_reg[5]};
        end else begin
            src = '{bank_reg[2], bank_reg[3], bank_reg[4], bank_reg[5],
                    bank_reg[0], extra_page[0], bank_reg[1], extra_page[1]};
        end
        for (int s = 0; s < 8; s++) begin
            if (cfg_chr_total == 9'd0) begin
                m.ram[s] = 1'b1;
                page = 8'(s % RAM_PAGES);
            end else if (int'(src[s]) < RAM_PAGES) begin
                m.ram[s] = 1'b1;
                page = src[s];
            end else begin
                m.ram[s] = 1'b0;
                page = 8'(int'(src[s]) % int'(cfg_chr_total));
            end
            if (s < 4) m.chr_lo[8*s +: 8] = page;
            else m.chr_hi[8*(s-4) +: 8] = page;
        end
        m.nt = cfg_four ? NT_FOUR_SCREEN : {1'b0, mirror_reg};
        return m;
    endfunction

    function automatic t_plan_row wr(logic [15:0] addr, logic [7:0] data);
        t_plan_row row;
        row = '{ROW_CHECKED, '{1'b0, addr, data, 1'b0}, '0, 8'd0, 9'd0, 1'b0};
        return row;
    endfunction

    function automatic t_plan_row tk(logic rend);
        t_plan_row row;
        row = '{ROW_CHECKED, '{1'b1, 16'h0000, 8'h00, rend}, '0, 8'd0, 9'd0, 1'b0};
        return row;
    endfunction

    function automatic t_plan_row typed(t_plan_row row, t_mapping m);
        t_plan_row t;
        t = row;
        t.op = ROW_TYPED;
        t.gold = m;
        return t;
    endfunction

    function automatic t_plan_row setup(logic [7:0] p, logic [8:0] c, logic f);
        t_plan_row row;
        row = '{ROW_SETUP, '0, '0, p, c, f};
        return row;
    endfunction

    // Scanline ticks and mostly well-formed register writes with random content, plus a share of noise.
    function automatic t_map_req random_request();
        t_map_req    r;
        int unsigned pick;
        logic [15:0] spare;
        pick = $urandom_range(99);
        spare = 16'($urandom) & ~ADDR_MASK;
        r.kind = 1'b0;
        r.data = 8'($urandom);
        r.rend = 1'($urandom_range(1));
        r.addr = 16'($urandom);
        if (pick < 30) begin
            r.kind = 1'b1;
            r.rend = ($urandom_range(9) < 8);
        end else if (pick < 45) begin
            r.addr = ADDR_BANK_SELECT | spare;
        end else if (pick < 65) begin
            r.addr = ADDR_BANK_DATA | spare;
            if ($urandom_range(2) == 0) r.data = 8'($urandom_range(15));
        end else if (pick < 70) begin
            r.addr = ADDR_MIRROR | spare;
        end else if (pick < 78) begin
            r.addr = ADDR_IRQ_LATCH | spare;
            if ($urandom_range(3) != 0) r.data = 8'($urandom_range(4));
        end else if (pick < 85) begin
            r.addr = ADDR_IRQ_RELOAD | spare;
        end else if (pick < 90) begin
            r.addr = ADDR_IRQ_DISABLE | spare;
        end else if (pick < 95) begin
            r.addr = ADDR_IRQ_ENABLE | spare;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_request(input t_map_req r, input logic use_gold, input t_mapping gold);
        t_mapping m;
        while (!steady && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        m = apply_request(r);
        mapping_q.push_back(use_gold ? gold : m);
        @(negedge clk);
    endtask

    task automatic cfg_poke(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Board setup changes only once every outstanding mapping has come back.
    task automatic apply_settings(input logic [7:0] p, input logic [8:0] c, input logic f);
        in_valid <= 1'b0;
        while (mapping_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_poke(CFG_PRG_TOTAL, {1'b0, p});
        cfg_poke(CFG_CHR_TOTAL, c);
        cfg_poke(CFG_FOUR_SCREEN, {8'd0, f});
        cfg_prg_total = p;
        cfg_chr_total = c;
        cfg_four = f;
    endtask

    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 33);
    end

    always @(posedge clk) begin
        t_mapping got;
        t_mapping want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.prg_banks, res_if.chr_banks_low, res_if.chr_banks_high,
                    res_if.chr_ram_slots, res_if.nametable_mode, res_if.irq_request,
                    res_if.irq_acknowledge};
            if (mapping_q.size() == 0) begin
                $error("mapping reported with no request outstanding");
                fail_count++;
            end else begin
                want = mapping_q.pop_front();
                if (got.prg !== want.prg) begin
                    $error("prg_banks expected %h got %h", want.prg, got.prg);
                    fail_count++;
                end
                if (got.chr_lo !== want.chr_lo) begin
                    $error("chr_banks_low expected %h got %h", want.chr_lo, got.chr_lo);
                    fail_count++;
                end
                if (got.chr_hi !== want.chr_hi) begin
                    $error("chr_banks_high expected %h got %h", want.chr_hi, got.chr_hi);
                    fail_count++;
                end
                if (got.ram !== want.ram) begin
                    $error("chr_ram_slots expected %h got %h", want.ram, got.ram);
                    fail_count++;
                end
                if (got.nt !== want.nt) begin
                    $error("nametable_mode expected %0d got %0d", want.nt, got.nt);
                    fail_count++;
                end
                if (got.irq_req !== want.irq_req) begin
                    $error("irq_request expected %b got %b", want.irq_req, got.irq_req);
                    fail_count++;
                end
                if (got.irq_ack !== want.irq_ack) begin
                    $error("irq_acknowledge expected %b got %b", want.irq_ack, got.irq_ack);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && item_if.ready) || (res_if.valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL mmc3_clone_bank_mapper_irq_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        plan = '{
            typed(tk(1'b0), POWER_ON_MAP),
            typed(wr(16'hFFFE, 8'hFF), POWER_ON_ACK_MAP),
            setup(8'd0, 9'd256, 1'b0),
            wr(16'h8000, 8'h46),    // select R6, swapped program order
            wr(16'h8001, 8'hFF),
            wr(16'h8000, 8'h87),    // select R7, swapped pattern order
            wr(16'h8001, 8'h00),
            wr(16'h8000, 8'h03),
            wr(16'h8001, 8'h08),    // first ROM page number
            wr(16'h8000, 8'h0A),
            wr(16'h8001, 8'hFF),
            wr(16'h8000, 8'h0B),
            wr(16'h8001, 8'h07),    // last RAM page number
            wr(16'h8000, 8'hC8),
            wr(16'h8001, 8'h5A),    // selector not connected to any register
            wr(16'hA000, 8'hFF),
            wr(16'hA001, 8'h01),
            wr(16'h0000, 8'hFF),
            wr(16'hC000, 8'h02),
            wr(16'hC001, 8'h00),
            wr(16'hFFFF, 8'h00),
            tk(1'b1),
            tk(1'b0),
            tk(1'b1),
            tk(1'b1),
            wr(16'hE000, 8'h00),
            setup(8'd1, 9'd9, 1'b1),
            tk(1'b1),
            setup(8'd255, 9'd0, 1'b0),
            wr(16'h8000, 8'h0F)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[n]) begin
            case (plan[n].op)
                ROW_SETUP:   apply_settings(plan[n].prg_total, plan[n].chr_total, plan[n].four);
                ROW_TYPED:   push_request(plan[n].req, 1'b1, plan[n].gold);
                default:     push_request(plan[n].req, 1'b0, '0);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 7) apply_settings(PH_PRG[ph], PH_CHR[ph], PH_FOUR[ph]);
            else apply_settings(8'($urandom), 9'($urandom), 1'($urandom));
            // One phase runs with both sides always willing.
            steady = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) push_request(random_request(), 1'b0, '0);
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (mapping_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS mmc3_clone_bank_mapper_irq_core");
        end else begin
            $display("FAIL mmc3_clone_bank_mapper_irq_core");
        end
        $finish;
    end

endmodule

>>> mmc3_clone_bank_mapper_irq_core.f
sv/mmc3c_pkg.sv
sv/mmc3c_in_if.sv
sv/mmc3c_out_if.sv
sv/mmc3c_ctrl.sv
sv/mmc3c_dp.sv
sv/mmc3_clone_bank_mapper_irq_core.sv
sv/mmc3c_chk.sv
tb/tb_mmc3_clone_bank_mapper_irq_core.sv
